>>> rtl/murmur3_32_key_hash_defines.svh
// Assertion macros shared by the murmur3_32_key_hash RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef MURMUR3_32_KEY_HASH_DEFINES_SVH
`define MURMUR3_32_KEY_HASH_DEFINES_SVH

// Generic clocked check, disabled while the active-low reset is asserted.
`define M3KH_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// House form: every module in this block runs on aclk / aresetn.
`define M3KH_ASSERT(label, prop, msg) \
    `M3KH_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

>>> rtl/m3kh_pkg.sv
// Package for murmur3_32_key_hash: constants, state type and interface structs.
// Used by m3kh_mul, m3kh_core and murmur3_32_key_hash; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package m3kh_pkg;

    localparam int          WORD_W          = 32;
    localparam int          KEY_WORDS_W     = 5;
    localparam int          DIGIT_W         = 8;
    localparam int          MAX_KEY_WORDS   = 16;

    localparam logic [31:0] SEED_RESET      = 32'd23;
    localparam logic [4:0]  KEY_WORDS_RESET = 5'd5;

    localparam logic [31:0] C1       = 32'hcc9e2d51;
    localparam logic [31:0] C2       = 32'h1b873593;
    localparam logic [31:0] C_ADD    = 32'he6546b64;
    localparam logic [31:0] FMIX_C1  = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2  = 32'hc2b2ae35;
    localparam int          ROT_K    = 15;
    localparam int          ROT_H    = 13;
    localparam int          FMIX_SH1 = 16;
    localparam int          FMIX_SH2 = 13;

    // register map: index is paddr[2]
    localparam logic REG_SEED      = 1'b0;
    localparam logic REG_KEY_WORDS = 1'b1;

    typedef enum logic [2:0] {
        M3_IDLE,
        M3_MUL1,
        M3_MUL2,
        M3_FIN1,
        M3_FIN2,
        M3_OUT
    } m3_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] mcand;
        logic [31:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic in_ready;
        logic res_valid;
    } core_stat_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        rotl32 = (v << s) | (v >> (WORD_W - s));
    endfunction

endpackage

`default_nettype wire

>>> rtl/murmur3_32_key_hash.sv
// Top level of murmur3_32_key_hash: APB registers, input word channel, hash output register.
// Instantiates m3kh_core and m3kh_mul; depends on m3kh_pkg and the defines header.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------
//  s_       | in  | s_valid / s_ready  | s_key_word[31:0]
//  m_       | out | m_valid / m_ready  | m_hash_value[31:0]
//  apb      | in  | psel/penable/pready| paddr[2:0] pwdata/prdata[31:0]
//
// Each key word takes two products on the one shared multiplier (four 8-bit digit passes
// and a done strobe per product); s_ready returns after a non-final word's products. The final
// word adds two finalization products, then the result loads the output register and m_valid
// rises once the output register is free. s_ready is low meanwhile.
// Reset (aresetn low, synchronous) loads seed = 23, key_words = 5, empty output.
// A stalled m_ready holds a second result in the sequencer; no new word is taken while one waits.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_32_key_hash_defines.svh"

module murmur3_32_key_hash #(
    parameter int MAX_KEY_WORDS = m3kh_pkg::MAX_KEY_WORDS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_key_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_hash_value
);

    logic [31:0]                      seed_reg, seed_next;
    logic [m3kh_pkg::KEY_WORDS_W-1:0] kw_reg, kw_next;
    logic                             m_valid_reg, m_valid_next;
    logic [31:0]                      m_hash_reg, m_hash_next;
    logic                             wr_en, out_free;
    logic [31:0]                      res_hash;
    m3kh_pkg::core_stat_t             stat;
    m3kh_pkg::mul_req_t               mul_req;
    m3kh_pkg::mul_rsp_t               mul_rsp;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb begin
        seed_next = seed_reg;
        kw_next   = kw_reg;
        if (wr_en) begin
            unique case (paddr[2])
                m3kh_pkg::REG_SEED:      seed_next = pwdata;
                m3kh_pkg::REG_KEY_WORDS: kw_next   = pwdata[m3kh_pkg::KEY_WORDS_W-1:0];
                default:                 seed_next = seed_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            m3kh_pkg::REG_SEED:      prdata = seed_reg;
            m3kh_pkg::REG_KEY_WORDS: prdata = 32'(kw_reg);
            default:                 prdata = '0;
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_hash_next  = m_hash_reg;
        priority if (stat.res_valid) begin
            m_valid_next = 1'b1;
            m_hash_next  = res_hash;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= m3kh_pkg::SEED_RESET;
            kw_reg      <= m3kh_pkg::KEY_WORDS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            seed_reg    <= seed_next;
            kw_reg      <= kw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hash_reg <= m_hash_next;
    end

    assign s_ready      = stat.in_ready;
    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    m3kh_core #(
        .MAX_KEY_WORDS(MAX_KEY_WORDS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_word   (s_key_word),
        .seed      (seed_reg),
        .key_words (kw_reg),
        .out_free  (out_free),
        .stat      (stat),
        .res_hash  (res_hash),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp)
    );

    m3kh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    `M3KH_ASSERT(a_top_accept_no_push, (s_valid && s_ready) |-> !stat.res_valid, "word accepted while a result is pushed")

endmodule

`default_nettype wire

>>> rtl/m3kh_mul.sv
// Digit-serial 32x32 multiplier, low 32 bits of the product, one digit a cycle.
// Depends on m3kh_pkg and murmur3_32_key_hash_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_32_key_hash_defines.svh"

module m3kh_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire m3kh_pkg::mul_req_t req,
    output m3kh_pkg::mul_rsp_t      rsp
);

    localparam int DIGITS = m3kh_pkg::WORD_W / m3kh_pkg::DIGIT_W;
    localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIGITS - 1);

    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      mc_reg, mc_next;
    logic [31:0]      mp_reg, mp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [31+m3kh_pkg::DIGIT_W:0] partial;

    assign partial = mc_reg * mp_reg[m3kh_pkg::DIGIT_W-1:0];

    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        priority if (req.start) begin
            acc_next  = '0;
            mc_next   = req.mcand;
            mp_next   = req.mplier;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // multiplicand moves up one digit as the multiplier moves down
            acc_next = acc_reg + partial[31:0];
            mc_next  = mc_reg << m3kh_pkg::DIGIT_W;
            mp_next  = mp_reg >> m3kh_pkg::DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    `M3KH_ASSERT(a_mul_start_idle, req.start |-> !busy_reg, "multiplier restarted while busy")

endmodule

`default_nettype wire

>>> rtl/m3kh_core.sv
// Sequencer for the MurmurHash3 word mix and fmix32 finalization.
// Drives the shared multiplier; depends on m3kh_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_32_key_hash_defines.svh"

module m3kh_core #(
    parameter int MAX_KEY_WORDS = m3kh_pkg::MAX_KEY_WORDS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    input  wire logic [31:0]                        in_word,
    input  wire logic [31:0]                        seed,
    input  wire logic [m3kh_pkg::KEY_WORDS_W-1:0]   key_words,
    input  wire logic                               out_free,
    output m3kh_pkg::core_stat_t                     stat,
    output logic [31:0]                             res_hash,
    output m3kh_pkg::mul_req_t                       mul_req,
    input  wire m3kh_pkg::mul_rsp_t                  mul_rsp
);

    localparam int NW = $clog2(MAX_KEY_WORDS + 1);
    localparam int CW = (NW > m3kh_pkg::KEY_WORDS_W) ? NW : m3kh_pkg::KEY_WORDS_W;
    localparam logic [CW-1:0] N_MAX = CW'(MAX_KEY_WORDS);

    m3kh_pkg::m3_state_t state_reg, state_next;
    logic [31:0]   h_reg, h_next;
    logic [31:0]   run_reg, run_next;
    logic [CW-1:0] wt_reg, wt_next;

    logic [CW-1:0] kw_ext, n_eff, wt_inc;
    logic [31:0]   prod, x, r, hmix, hlen, fin_a;

    // clamp length to 1..MAX_KEY_WORDS
    always_comb begin
        kw_ext = CW'(key_words);
        priority if (kw_ext == '0) begin
            n_eff = CW'(1);
        end else if (kw_ext > N_MAX) begin
            n_eff = N_MAX;
        end else begin
            n_eff = kw_ext;
        end
    end

    assign prod   = mul_rsp.product;
    assign wt_inc = wt_reg + 1'b1;
    assign x      = h_reg ^ prod;
    assign r      = m3kh_pkg::rotl32(x, m3kh_pkg::ROT_H);
    assign hmix   = (r << 2) + r + m3kh_pkg::C_ADD;
    assign hlen   = hmix ^ 32'({n_eff, 2'b00});
    assign fin_a  = hlen ^ (hlen >> m3kh_pkg::FMIX_SH1);
    assign res_hash = prod ^ (prod >> m3kh_pkg::FMIX_SH1);

    always_comb begin
        state_next     = state_reg;
        h_next         = h_reg;
        run_next       = run_reg;
        wt_next        = wt_reg;
        mul_req.start  = 1'b0;
        mul_req.mcand  = '0;
        mul_req.mplier = '0;
        stat.in_ready  = (state_reg == m3kh_pkg::M3_IDLE);
        stat.res_valid = 1'b0;
        unique case (state_reg)
            m3kh_pkg::M3_IDLE: begin
                if (in_valid) begin
                    // first word of a key starts from the current seed
                    h_next         = (wt_reg == '0) ? seed : run_reg;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = in_word;
                    mul_req.mplier = m3kh_pkg::C1;
                    state_next     = m3kh_pkg::M3_MUL1;
                end
            end
            m3kh_pkg::M3_MUL1: begin
                if (mul_rsp.done) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = m3kh_pkg::rotl32(prod, m3kh_pkg::ROT_K);
                    mul_req.mplier = m3kh_pkg::C2;
                    state_next     = m3kh_pkg::M3_MUL2;
                end
            end
            m3kh_pkg::M3_MUL2: begin
                if (mul_rsp.done) begin
                    if (wt_inc < n_eff) begin
                        run_next   = hmix;
                        wt_next    = wt_inc;
                        state_next = m3kh_pkg::M3_IDLE;
                    end else begin
                        wt_next        = '0;
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = fin_a;
                        mul_req.mplier = m3kh_pkg::FMIX_C1;
                        state_next     = m3kh_pkg::M3_FIN1;
                    end
                end
            end
            m3kh_pkg::M3_FIN1: begin
                if (mul_rsp.done) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = prod ^ (prod >> m3kh_pkg::FMIX_SH2);
                    mul_req.mplier = m3kh_pkg::FMIX_C2;
                    state_next     = m3kh_pkg::M3_FIN2;
                end
            end
            m3kh_pkg::M3_FIN2: begin
                if (mul_rsp.done) begin
                    state_next = m3kh_pkg::M3_OUT;
                end
            end
            m3kh_pkg::M3_OUT: begin
                // product register holds until the next start
                if (out_free) begin
                    stat.res_valid = 1'b1;
                    state_next     = m3kh_pkg::M3_IDLE;
                end
            end
            default: begin
                state_next = m3kh_pkg::M3_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= m3kh_pkg::M3_IDLE;
            wt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            wt_reg    <= wt_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg   <= h_next;
        run_reg <= run_next;
    end

    `M3KH_ASSERT(a_core_idle_mul, (state_reg == m3kh_pkg::M3_IDLE) |-> !mul_rsp.busy, "multiplier busy while sequencer idle")
    `M3KH_ASSERT(a_core_push_free, stat.res_valid |-> out_free, "result pushed into a full output register")

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for murmur3_32_key_hash: streams key words, writes the seed and
// key length over APB, predicts every finalized hash and checks it on the m_ channel.
// Depends on m3kh_pkg and the murmur3_32_key_hash RTL.
`timescale 1ns / 1ps

class key_hash_tracker;
    logic [31:0] seed;
    logic [4:0]  key_words;
    logic [31:0] running_hash;
    int          words_taken;
    logic [31:0] hash_due[$];
    int          checked;
    int          mismatches;

    function new();
        seed         = m3kh_pkg::SEED_RESET;
        key_words    = m3kh_pkg::KEY_WORDS_RESET;
        running_hash = m3kh_pkg::SEED_RESET;
        words_taken  = 0;
        checked      = 0;
        mismatches   = 0;
    endfunction

    function logic [31:0] rol(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Mix one accepted key word; queue the finalized hash when the key completes.
    function void take_word(input logic [31:0] w);
        logic [31:0] k;
        logic [31:0] h;
        int          n;
        n = key_words;
        if (n < 1)
            n = 1;
        if (n > m3kh_pkg::MAX_KEY_WORDS)
            n = m3kh_pkg::MAX_KEY_WORDS;
        h = (words_taken == 0) ? seed : running_hash;
        k = w * m3kh_pkg::C1;
        k = rol(k, m3kh_pkg::ROT_K) * m3kh_pkg::C2;
        h = h ^ k;
        h = rol(h, m3kh_pkg::ROT_H) * 32'd5 + m3kh_pkg::C_ADD;
        words_taken++;
        if (words_taken < n) begin
            running_hash = h;
            return;
        end
        h = h ^ 32'(n * 4);
        h = h ^ (h >> 16);
        h = h * m3kh_pkg::FMIX_C1;
        h = h ^ (h >> 13);
        h = h * m3kh_pkg::FMIX_C2;
        h = h ^ (h >> 16);
        hash_due.push_back(h);
        running_hash = seed;
        words_taken  = 0;
    endfunction

    function void report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %08h, got %08h", $time, what, want, got);
    endfunction

    function void compare_hash(input logic [31:0] got);
        logic [31:0] want;
        checked++;
        if (hash_due.size() == 0) begin
            report("hash with none pending", 32'h0, got);
            return;
        end
        want = hash_due.pop_front();
        if (got !== want)
            report("hash_value mismatch", want, got);
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_WORDS = 1300;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_key_word;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;

    key_hash_tracker hashes = new();
    int              cycles = 0;
    bit              no_idle = 1'b0;
    int              hold_left = 0;

    murmur3_32_key_hash u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_word   (s_key_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("murmur3_32_key_hash test failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function int draw_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // entered and left at a falling edge
    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == m3kh_pkg::REG_SEED)
            hashes.seed = val;
        else
            hashes.key_words = val[4:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // valid stays high into the next word when no gap is drawn
    task automatic push_word(input logic [31:0] w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_key_word = w;
        do @(posedge aclk); while (!s_ready);
        hashes.take_word(w);
        @(negedge aclk);
    endtask

    // drain all pending hashes, then give a non-final word time to finish mixing
    task automatic settle();
        s_valid = 1'b0;
        while (hashes.hash_due.size() != 0)
            @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (no_idle || $urandom_range(0, 99) < 70) begin
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b0;
                hold_left = draw_gap();
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                hashes.compare_hash(m_hash_value);
                // long back-pressure so the core fills and drops s_ready
                if (hashes.checked % 150 == 40)
                    hold_left = 700;
            end
        end
    end

    initial begin
        int          sent;
        int          count;
        logic [31:0] w;
        logic [4:0]  len;

        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_key_word = '0;
        sent       = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset values: seed 23, five-word keys
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        push_word(32'h8000_0000);
        push_word(32'h0000_0001);
        push_word(32'ha5a5_a5a5);
        settle();
        reg_write(m3kh_pkg::REG_SEED, 32'h0);
        reg_write(m3kh_pkg::REG_KEY_WORDS, 32'd1);
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        settle();
        // zero length acts as one word
        reg_write(m3kh_pkg::REG_SEED, 32'hffff_ffff);
        reg_write(m3kh_pkg::REG_KEY_WORDS, 32'd0);
        push_word(32'h5a5a_5a5a);
        settle();
        // oversize length clamps; key left open, then cut short under a new seed
        reg_write(m3kh_pkg::REG_KEY_WORDS, 32'd31);
        push_word(32'h0123_4567);
        push_word(32'h89ab_cdef);
        push_word(32'h7fff_ffff);
        settle();
        reg_write(m3kh_pkg::REG_SEED, 32'hdead_beef);
        reg_write(m3kh_pkg::REG_KEY_WORDS, 32'd2);
        push_word(32'hfedc_ba98);
        settle();
        // seed change inside a key keeps its running hash
        reg_write(m3kh_pkg::REG_KEY_WORDS, 32'd3);
        push_word(32'h0000_ffff);
        settle();
        reg_write(m3kh_pkg::REG_SEED, 32'h1357_9bdf);
        push_word(32'hffff_fffe);
        push_word(32'hffff_0000);
        settle();

        while (sent < RANDOM_WORDS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0:       w = 32'h0;
                    1:       w = 32'hffff_ffff;
                    default: w = $urandom();
                endcase
                reg_write(m3kh_pkg::REG_SEED, w);
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: len = 5'($urandom_range(1, 4));
                    12, 13, 14, 15, 16:                   len = 5'($urandom_range(5, 16));
                    17:                                   len = 5'd16;
                    18:                                   len = 5'd0;
                    default:                              len = 5'($urandom_range(17, 31));
                endcase
                reg_write(m3kh_pkg::REG_KEY_WORDS, {27'h0, len});
            end
            count = $urandom_range(5, 60);
            repeat (count) begin
                case ($urandom_range(0, 39))
                    0:       w = 32'h0;
                    1:       w = 32'hffff_ffff;
                    default: w = $urandom();
                endcase
                push_word(w);
                sent++;
            end
            settle();
        end

        repeat (50) @(negedge aclk);
        if (hashes.mismatches == 0 && hashes.hash_due.size() == 0)
            $display("murmur3_32_key_hash test passed");
        else
            $display("murmur3_32_key_hash test failed");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/m3kh_pkg.sv
rtl/m3kh_mul.sv
rtl/m3kh_core.sv
rtl/murmur3_32_key_hash.sv
bench/testbench.sv
